>>> sv/rlc_pkg.sv
`timescale 1ns / 1ps

package rlc_pkg;

  // Cut mode codes, shared by the cut_mode register and the active mode
  localparam logic [2:0] CUT_OFF     = 3'd0;
  localparam logic [2:0] CUT_SOFT    = 3'd1;
  localparam logic [2:0] CUT_HARD    = 3'd2;
  localparam logic [2:0] CUT_PATTERN = 3'd3;
  localparam logic [2:0] CUT_PROG    = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] REG_MAIN_LIMIT    = 3'd0;
  localparam logic [2:0] REG_OVERREV_LIMIT = 3'd1;
  localparam logic [2:0] REG_CUT_MODE      = 3'd2;
  localparam logic [2:0] REG_MAIN_RETARD   = 3'd3;
  localparam logic [2:0] REG_FIRE_COUNT    = 3'd4;
  localparam logic [2:0] REG_SKIP_COUNT    = 3'd5;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 15;

  localparam logic [31:0] RPM_NUMERATOR = 32'd60000000;
  localparam logic [31:0] LCG_MUL       = 32'd1664525;
  localparam logic [31:0] LCG_INC       = 32'd1013904223;
  localparam logic [31:0] LCG_SEED_INIT = 32'hDEADBEEF;

  typedef struct packed {
    logic        cmd;
    logic [31:0] period_us;
    logic [15:0] smooth_rpm;
    logic [31:0] now_ms;
    logic        alvp_low_cut;
    logic        alvp_derated;
    logic [15:0] derate_limit_rpm;
    logic        launch_en;
    logic [15:0] launch_limit_rpm;
    logic        rumble_allow;
    logic        flame_allow;
  } in_item_t;

  typedef struct packed {
    logic        fire;
    logic        rev_limited;
    logic        overrev_cut;
    logic [2:0]  active_mode;
    logic [8:0]  active_retard_tenths;
    logic [6:0]  skip_pct;
    logic [15:0] rpm_now;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RPM_DIV,
    ST_TICK_EVAL,
    ST_PCT_DIV,
    ST_SPARK_EVAL,
    ST_MOD_DIV,
    ST_DRAW,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic load;
    logic rpm_wb;
    logic tick_eval;
    logic pct_wb;
    logic spark_eval;
    logic spark_fin;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic is_spark;
    logic period_zero;
    logic div_done;
    logic need_pct;
    logic spark_div;
    logic spark_draw;
    logic out_free;
  } dp_stat_t;

endpackage

>>> sv/rlc_div.sv
`timescale 1ns / 1ps

module rlc_div import rlc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quo_o,
  output logic [31:0] rem_o
);

  logic        busy_q, busy_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] quo_q, quo_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] div_q, div_d;
  logic [32:0] partial;
  logic [32:0] trial;

  // restoring division, one quotient bit a cycle
  assign partial = {rem_q, quo_q[31]};
  assign trial   = partial - {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 6'd32;
      quo_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      if (cnt_q != 6'd0) begin
        cnt_d = cnt_q - 6'd1;
        if (!trial[32]) begin
          rem_d = trial[31:0];
          quo_d = {quo_q[30:0], 1'b1};
        end else begin
          rem_d = partial[31:0];
          quo_d = {quo_q[30:0], 1'b0};
        end
      end else begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o = busy_q && (cnt_q == 6'd0);
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

>>> sv/rlc_dp.sv
`timescale 1ns / 1ps

module rlc_dp import rlc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  in_item_t            in_data_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output out_item_t           out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  dp_cmd_t             cmd_i,
  output dp_stat_t            stat_o
);

  // configuration
  logic [14:0] main_q, ovr_q;
  logic [2:0]  mode_cfg_q;
  logic [8:0]  retard_cfg_q;
  logic [3:0]  fcnt_q, scnt_q;

  // limiter state
  in_item_t    item_q;
  logic [15:0] rpm_q;
  logic        limited_q, overrev_q, uv_q, fire_q;
  logic [2:0]  amode_q;
  logic [8:0]  aretard_q;
  logic [6:0]  skip_q;
  logic [31:0] pcount_q, seed_q, ent_time_q;
  logic [15:0] ent_speed_q;
  logic        out_valid_q;
  out_item_t   out_q;

  // config clamps
  logic [14:0] m_in, o_in, m_c, o_c;
  logic [15:0] m_sum, o_1;

  always_comb begin
    m_in  = (cfg_idx_i == REG_MAIN_LIMIT) ? cfg_wdata_i : main_q;
    o_in  = (cfg_idx_i == REG_OVERREV_LIMIT) ? cfg_wdata_i : ovr_q;
    m_c   = (m_in < 15'd1000) ? 15'd1000 : m_in;
    m_sum = {1'b0, m_c} + 16'd200;
    o_1   = ({1'b0, o_in} < m_sum) ? m_sum : {1'b0, o_in};
    o_c   = (o_1 > 16'd20000) ? 15'd20000 : o_1[14:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_q       <= 15'd10000;
      ovr_q        <= 15'd11500;
      mode_cfg_q   <= CUT_SOFT;
      retard_cfg_q <= 9'd100;
      fcnt_q       <= 4'd3;
      scnt_q       <= 4'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MAIN_LIMIT, REG_OVERREV_LIMIT: begin
          main_q <= m_c;
          ovr_q  <= o_c;
        end
        REG_CUT_MODE:    mode_cfg_q   <= (cfg_wdata_i[2:0] > CUT_PROG) ? CUT_OFF
                                                                      : cfg_wdata_i[2:0];
        REG_MAIN_RETARD: retard_cfg_q <= (cfg_wdata_i[8:0] > 9'd300) ? 9'd300
                                                                      : cfg_wdata_i[8:0];
        REG_FIRE_COUNT:  fcnt_q <= (cfg_wdata_i[3:0] == 4'd0) ? 4'd1 : cfg_wdata_i[3:0];
        REG_SKIP_COUNT:  scnt_q <= (cfg_wdata_i[3:0] == 4'd0) ? 4'd1 : cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  // divider
  logic        div_start, div_done;
  logic [31:0] div_a, div_b, div_quo, div_rem;

  rlc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  // tick evaluation
  logic [15:0] eff, ovr16, es, bdiff, diff16;
  logic [2:0]  mode;
  logic [31:0] et;
  logic        is_over, in_lim, ent_new, climb, dwell_over, release_ok, need_pct;
  logic [8:0]  band;
  logic [22:0] num;

  always_comb begin
    eff  = {1'b0, main_q};
    mode = mode_cfg_q;
    if (item_q.alvp_derated && (item_q.derate_limit_rpm < eff)) begin
      eff  = item_q.derate_limit_rpm;
      mode = CUT_SOFT;
    end
    if (item_q.launch_en) begin
      eff  = item_q.launch_limit_rpm;
      mode = CUT_HARD;
    end
    ovr16      = {1'b0, ovr_q};
    is_over    = rpm_q > ovr16;
    in_lim     = (rpm_q > eff) && (item_q.smooth_rpm > eff);
    ent_new    = (ent_time_q == 32'd0);
    et         = ent_new ? item_q.now_ms : ent_time_q;
    es         = ent_new ? rpm_q : ent_speed_q;
    climb      = {1'b0, rpm_q} > ({1'b0, es} + 17'd50);
    dwell_over = (item_q.now_ms - et) > 32'd400;
    bdiff      = (ovr16 > eff) ? (ovr16 - eff) : 16'd0;
    band       = (bdiff > 16'd300) ? 9'd300
               : (bdiff == 16'd0) ? 9'd1 : bdiff[8:0];
    diff16     = rpm_q - eff;
    num        = 23'(diff16) * 23'd100;
    need_pct   = !is_over && in_lim && (mode == CUT_PROG);
    release_ok = ({1'b0, rpm_q} + 17'd75) < {1'b0, eff};
  end

  // spark evaluation
  logic        gate_off, spark_div, spark_draw, fire_fin;
  logic [31:0] seed_nx;
  logic [4:0]  period_len;
  logic [32:0] lcg_prod;
  logic [9:0]  lcg_quo;
  logic [15:0] lcg_rem;

  always_comb begin
    gate_off   = uv_q || !item_q.rumble_allow || !item_q.flame_allow;
    seed_nx    = seed_q * LCG_MUL + LCG_INC;
    spark_div  = !gate_off && (amode_q == CUT_PATTERN);
    spark_draw = !gate_off &&
                 (((amode_q == CUT_HARD) && !overrev_q && !item_q.launch_en) ||
                  (amode_q == CUT_PROG));
    period_len = {1'b0, fcnt_q} + {1'b0, scnt_q};
    // upper seed half modulo 100 by reciprocal multiply, exact for 16 bits
    lcg_prod   = {17'd0, seed_q[31:16]} * 33'd83887;
    lcg_quo    = lcg_prod[32:23];
    lcg_rem    = seed_q[31:16] - ({6'd0, lcg_quo} * 16'd100);
    case (amode_q)
      CUT_HARD:    fire_fin = lcg_rem < 16'd8;
      CUT_PATTERN: fire_fin = div_rem < {28'd0, fcnt_q};
      CUT_PROG:    fire_fin = lcg_rem >= {9'd0, skip_q};
      default:     fire_fin = 1'b1;
    endcase
  end

  // pick divider operands for whichever step starts it
  always_comb begin
    div_start = 1'b0;
    div_a     = RPM_NUMERATOR;
    div_b     = in_data_i.period_us;
    if (cmd_i.load) begin
      div_start = !in_data_i.cmd && (in_data_i.period_us != 32'd0);
    end else if (cmd_i.tick_eval) begin
      div_start = need_pct;
      div_a     = {9'd0, num};
      div_b     = {23'd0, band};
    end else if (cmd_i.spark_eval) begin
      div_start = spark_div;
      div_a     = pcount_q;
      div_b     = {27'd0, period_len};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rpm_q       <= '0;
      limited_q   <= 1'b0;
      overrev_q   <= 1'b0;
      uv_q        <= 1'b0;
      fire_q      <= 1'b0;
      amode_q     <= CUT_OFF;
      aretard_q   <= '0;
      skip_q      <= '0;
      pcount_q    <= '0;
      seed_q      <= LCG_SEED_INIT;
      ent_time_q  <= '0;
      ent_speed_q <= '0;
    end else begin
      if (cmd_i.load && !in_data_i.cmd) begin
        fire_q <= 1'b0;
        uv_q   <= in_data_i.alvp_low_cut;
        if (in_data_i.period_us == 32'd0) begin
          rpm_q <= in_data_i.smooth_rpm;
        end
      end
      if (cmd_i.rpm_wb) begin
        rpm_q <= (div_quo > 32'd65535) ? 16'hFFFF : div_quo[15:0];
      end
      if (cmd_i.tick_eval) begin
        if (is_over) begin
          overrev_q <= 1'b1;
          limited_q <= 1'b1;
          amode_q   <= CUT_HARD;
          aretard_q <= '0;
          skip_q    <= 7'd100;
        end else if (in_lim) begin
          overrev_q <= 1'b0;
          limited_q <= 1'b1;
          if (mode == CUT_SOFT) begin
            ent_time_q  <= et;
            ent_speed_q <= es;
            skip_q      <= '0;
            if (climb || dwell_over) begin
              amode_q   <= CUT_PATTERN;
              aretard_q <= '0;
            end else begin
              amode_q   <= mode;
              aretard_q <= retard_cfg_q;
            end
          end else begin
            amode_q   <= mode;
            aretard_q <= '0;
            skip_q    <= (mode == CUT_HARD) ? 7'd100 : 7'd0;
          end
        end else begin
          overrev_q  <= 1'b0;
          if (release_ok) begin
            limited_q <= 1'b0;
          end
          amode_q    <= CUT_OFF;
          aretard_q  <= '0;
          skip_q     <= '0;
          ent_time_q <= '0;
        end
      end
      if (cmd_i.pct_wb) begin
        skip_q <= (div_quo > 32'd95) ? 7'd95 : div_quo[6:0];
      end
      if (cmd_i.spark_eval) begin
        fire_q <= !gate_off && (amode_q != CUT_HARD);
        if (spark_draw) begin
          seed_q <= seed_nx;
        end
        if (spark_div) begin
          pcount_q <= pcount_q + 32'd1;
        end
      end
      if (cmd_i.spark_fin) begin
        fire_q <= fire_fin;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.fire                 <= fire_q;
      out_q.rev_limited          <= limited_q;
      out_q.overrev_cut          <= overrev_q;
      out_q.active_mode          <= amode_q;
      out_q.active_retard_tenths <= aretard_q;
      out_q.skip_pct             <= skip_q;
      out_q.rpm_now              <= rpm_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign stat_o.is_spark    = in_data_i.cmd;
  assign stat_o.period_zero = (in_data_i.period_us == 32'd0);
  assign stat_o.div_done    = div_done;
  assign stat_o.need_pct    = need_pct;
  assign stat_o.spark_div   = spark_div;
  assign stat_o.spark_draw  = spark_draw;
  assign stat_o.out_free    = !out_valid_q || !out_stall_i;

  a_overrev_limited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    overrev_q |-> limited_q) else $error("overrev cut without limited state");
  a_skip_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skip_q <= 7'd100) else $error("skip percent out of range");
  a_retard_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    aretard_q <= 9'd300) else $error("active retard out of range");
  a_limits_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, ovr_q} >= ({1'b0, main_q} + 16'd200)) || (ovr_q == 15'd20000))
    else $error("overrev limit below main limit plus margin");

endmodule

>>> sv/rlc_ctrl.sv
`timescale 1ns / 1ps

module rlc_ctrl import rlc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = stat_i.is_spark ? ST_SPARK_EVAL
                  : stat_i.period_zero ? ST_TICK_EVAL : ST_RPM_DIV;
        end
      end
      ST_RPM_DIV:    if (stat_i.div_done) state_d = ST_TICK_EVAL;
      ST_TICK_EVAL:  state_d = stat_i.need_pct ? ST_PCT_DIV : ST_FINISH;
      ST_PCT_DIV:    if (stat_i.div_done) state_d = ST_FINISH;
      ST_SPARK_EVAL: state_d = stat_i.spark_div ? ST_MOD_DIV
                             : stat_i.spark_draw ? ST_DRAW : ST_FINISH;
      ST_MOD_DIV:    if (stat_i.div_done) state_d = ST_FINISH;
      ST_DRAW:       state_d = ST_FINISH;
      ST_FINISH:     if (stat_i.out_free) state_d = ST_IDLE;
      default:       state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE:       cmd_o.load       = in_valid_i;
      ST_RPM_DIV:    cmd_o.rpm_wb     = stat_i.div_done;
      ST_TICK_EVAL:  cmd_o.tick_eval  = 1'b1;
      ST_PCT_DIV:    cmd_o.pct_wb     = stat_i.div_done;
      ST_SPARK_EVAL: cmd_o.spark_eval = 1'b1;
      ST_MOD_DIV:    cmd_o.spark_fin  = stat_i.div_done;
      ST_DRAW:       cmd_o.spark_fin  = 1'b1;
      ST_FINISH:     cmd_o.out_load   = stat_i.out_free;
      default:       cmd_o = '0;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> sv/ignition_rev_limiter_cut_control.sv
`timescale 1ns / 1ps

// Rev limiter and spark-cut control. Each input transfer is either a tick
// (cmd 0), which works out engine speed as 60e6 / period_us (saturated at
// 65535, or the smoothed speed when the period is 0), selects the main,
// under-voltage derate or launch limit and updates the limiter state, or a
// spark request (cmd 1), which returns the fire decision from the gates,
// burn-through random draw, pattern counter or progressive skip. Each input
// transfer yields exactly one output transfer carrying the current limiter
// status. Items are handled one at a time by a state machine that drives a
// single shared 32-bit restoring divider. A tick divides only when the
// period is nonzero, then evaluates the limit, and divides once more when
// the progressive skip percentage is computed; a spark takes a draw step
// when it needs the random draw, or a division when it needs the pattern
// modulo. The input stall is high while an item is in flight; a
// finished result sits in the output register, so the next item is taken
// while it waits. Configuration writes apply clamps as they land and are
// meant to be issued only while the block is idle.
module ignition_rev_limiter_cut_control import rlc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequence the work of one item
  rlc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // hold configuration, limiter state, divider and output register
  rlc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule
